[rtl/srtf_pkg.sv]
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared constants and types for the shortest-remaining-time-first waiting
// time scheduler: cell contents, cell control and the scan result.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int TIME_BITS     = 16;

  localparam int IN_W       = 16;
  localparam int NUM_W      = 4;
  localparam int WAIT_W     = 20;
  localparam int IDX_W      = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int COUNT_W    = $clog2(MAX_PROCESSES + 1);
  localparam int CUR_TIME_W = TIME_BITS + $clog2(MAX_PROCESSES) + 1;
  localparam int SUM_W      = ((TIME_BITS > WAIT_W) ? TIME_BITS : WAIT_W) + 1;

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_APPLY,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                 valid;
    logic [IDX_W-1:0]     idx;
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] remaining;
    logic [WAIT_W-1:0]    wait_time;
  } cell_t;

  typedef struct packed {
    logic                  shift;
    logic                  apply;
    logic [IDX_W-1:0]      sel_idx;
    logic [TIME_BITS-1:0]  delta;
    logic [CUR_TIME_W-1:0] cur_time;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 any_left;
    logic                 have_run;
    logic [IDX_W-1:0]     best_idx;
    logic [TIME_BITS-1:0] best_rem;
    logic                 have_next;
    logic [TIME_BITS-1:0] next_arr;
  } scan_t;

endpackage

[rtl/srtf_cell.sv]
// ----------------------------------------------------------------------------
// srtf_cell
// One process slot of the ring. It either takes its neighbour's contents or
// applies one schedule step to its own remaining or waiting time.
// ----------------------------------------------------------------------------
module srtf_cell
  import srtf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_t      shift_in_i,
  output cell_t      cell_o
);

  cell_t                cell_q;
  cell_t                cell_d;
  logic                 active;
  logic [SUM_W-1:0]     wait_sum;

  always_comb begin
    active   = cell_q.valid && (cell_q.remaining != '0) &&
               (CUR_TIME_W'(cell_q.arrival) <= ctrl_i.cur_time);
    wait_sum = SUM_W'(cell_q.wait_time) + SUM_W'(ctrl_i.delta);
    cell_d   = cell_q;
    if (ctrl_i.shift) begin
      cell_d = shift_in_i;
    end else if (ctrl_i.apply && active) begin
      if (cell_q.idx == ctrl_i.sel_idx) begin
        cell_d.remaining = cell_q.remaining - ctrl_i.delta;
      end else if (wait_sum > SUM_W'(WAIT_MAX)) begin
        cell_d.wait_time = WAIT_MAX;
      end else begin
        cell_d.wait_time = wait_sum[WAIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[rtl/srtf_scan.sv]
// ----------------------------------------------------------------------------
// srtf_scan
// Watches the head of the ring as it rotates and keeps the shortest arrived
// job and the earliest pending arrival seen so far.
// ----------------------------------------------------------------------------
module srtf_scan
  import srtf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  en_i,
  input  cell_t                 head_i,
  input  logic [CUR_TIME_W-1:0] cur_time_i,
  output scan_t                 scan_o
);

  scan_t scan_q;
  scan_t scan_d;
  logic  live;
  logic  arrived;

  always_comb begin
    live    = head_i.valid && (head_i.remaining != '0);
    arrived = CUR_TIME_W'(head_i.arrival) <= cur_time_i;
    scan_d  = scan_q;
    if (clr_i) begin
      scan_d = '0;
    end else if (en_i && live) begin
      scan_d.any_left = 1'b1;
      if (arrived) begin
        if (!scan_q.have_run || (head_i.remaining < scan_q.best_rem) ||
            ((head_i.remaining == scan_q.best_rem) && (head_i.idx < scan_q.best_idx))) begin
          scan_d.have_run = 1'b1;
          scan_d.best_idx = head_i.idx;
          scan_d.best_rem = head_i.remaining;
        end
      end else if (!scan_q.have_next || (head_i.arrival < scan_q.next_arr)) begin
        scan_d.have_next = 1'b1;
        scan_d.next_arr  = head_i.arrival;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

[rtl/srtf_waiting_time_scheduler.sv]
// ----------------------------------------------------------------------------
// srtf_waiting_time_scheduler
// Processes are loaded one item per cycle; the item marked last_process closes
// the set, after which the block plays out preemptive shortest-remaining-time-
// first scheduling and returns each process's waiting time in load order. The
// set is held in a ring of MAX_PROCESSES cells. Each scheduling pass rotates
// the ring once past a single comparator at its head, chooses the step
// length and then applies that step to every cell at once; a pass in which
// nothing has arrived skips the apply step and only moves time forward. A
// pass ends either at the completion of the running job or at the next
// arrival, so a set of n processes takes at most 2n + 1 passes, the last of
// which only finds that nothing is left. Results then leave at one item per
// cycle while the output is not stalled, after the empty cells have been
// rotated past. While the schedule runs and results are emitted, the input is
// stalled; loading resumes once the final result has been taken.
// ----------------------------------------------------------------------------
module srtf_waiting_time_scheduler
  import srtf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [IN_W-1:0]   arrival_time_i,
  input  logic [IN_W-1:0]   burst_time_i,
  input  logic              last_process_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NUM_W-1:0]  process_number_o,
  output logic [WAIT_W-1:0] waiting_time_o,
  output logic              last_result_o
);

  state_e                state_q, state_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [CUR_TIME_W-1:0] time_q, time_d;
  logic [IDX_W-1:0]      rot_q, rot_d;
  logic [TIME_BITS-1:0]  delta_q, delta_d;

  cell_t                 ring [MAX_PROCESSES];
  cell_t                 tail_in;
  cell_t                 head;
  cell_ctrl_t            ctrl;
  scan_t                 scan;
  logic                  scan_clr;
  logic                  scan_en;
  logic                  in_acc;
  logic                  out_acc;
  logic                  is_last;
  logic [CUR_TIME_W-1:0] gap;

  assign head = ring[0];

  // The ring: each cell takes its upper neighbour, the top cell takes either
  // a freshly loaded process or the head coming round again.
  for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_cell
    cell_t nb;
    if (g == MAX_PROCESSES - 1) begin : g_tail
      assign nb = tail_in;
    end else begin : g_mid
      assign nb = ring[g+1];
    end
    srtf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .shift_in_i (nb),
      .cell_o     (ring[g])
    );
  end

  srtf_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (scan_clr),
    .en_i       (scan_en),
    .head_i     (head),
    .cur_time_i (time_q),
    .scan_o     (scan)
  );

  // Handshakes.  Results come straight from the head cell, which does not
  // move while the downstream side stalls.
  assign in_stall_o       = (state_q != ST_LOAD);
  assign in_acc           = in_valid_i && (state_q == ST_LOAD);
  assign out_valid_o      = (state_q == ST_EMIT) && head.valid;
  assign out_acc          = out_valid_o && !out_stall_i;
  assign is_last          = (head.idx == IDX_W'(count_q - 1'b1));
  assign process_number_o = NUM_W'(head.idx);
  assign waiting_time_o   = head.wait_time;
  assign last_result_o    = is_last;

  // Distance to the next pending arrival; that arrival is always later
  // than the present time.
  assign gap = CUR_TIME_W'(scan.next_arr) - time_q;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    time_d        = time_q;
    rot_d         = rot_q;
    delta_d       = delta_q;
    scan_clr      = 1'b0;
    scan_en       = 1'b0;
    ctrl.shift    = 1'b0;
    ctrl.apply    = 1'b0;
    ctrl.sel_idx  = scan.best_idx;
    ctrl.delta    = delta_q;
    ctrl.cur_time = time_q;
    tail_in       = head;

    unique case (state_q)
      ST_LOAD: begin
        tail_in.valid     = 1'b1;
        tail_in.idx       = count_q[IDX_W-1:0];
        tail_in.arrival   = TIME_BITS'(arrival_time_i);
        tail_in.remaining = TIME_BITS'(burst_time_i);
        tail_in.wait_time = '0;
        if (in_acc) begin
          // A full store drops the item, but its last flag still counts.
          if (count_q < COUNT_W'(MAX_PROCESSES)) begin
            ctrl.shift = 1'b1;
            count_d    = count_q + 1'b1;
          end
          if (last_process_i) begin
            scan_clr = 1'b1;
            rot_d    = '0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        scan_en    = 1'b1;
        rot_d      = rot_q + 1'b1;
        if (rot_q == IDX_W'(MAX_PROCESSES - 1)) begin
          rot_d   = '0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!scan.any_left) begin
          state_d = ST_EMIT;
        end else if (!scan.have_run) begin
          // Nothing has arrived yet: jump to the next arrival.
          time_d   = CUR_TIME_W'(scan.next_arr);
          scan_clr = 1'b1;
          state_d  = ST_SCAN;
        end else begin
          delta_d = scan.best_rem;
          if (scan.have_next && (gap < CUR_TIME_W'(scan.best_rem))) begin
            delta_d = gap[TIME_BITS-1:0];
          end
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        ctrl.apply = 1'b1;
        time_d     = time_q + CUR_TIME_W'(delta_q);
        scan_clr   = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_EMIT: begin
        // Emitted cells are freed as they rotate out; empty cells are skipped.
        tail_in.valid = 1'b0;
        ctrl.shift    = !head.valid || !out_stall_i;
        if (out_acc && is_last) begin
          count_d = '0;
          time_d  = '0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      time_q  <= '0;
      rot_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      time_q  <= time_d;
      rot_q   <= rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
  end

endmodule
